@@ src/etfp_pkg.sv @@
// Package for the escape-time fractal pixel block: widths, register indexes,
// reset values, controller states and the structs shared between modules.
// No dependencies.
`default_nettype none

package etfp_pkg;

  // fixed-point format of c (Q4.28 registers) and z (Q6.28 registers)
  localparam int FracBits   = 28;
  localparam int MaxColumns = 2048;
  localparam int MaxRows    = 1024;

  localparam int ColW   = 11;
  localparam int RowW   = 10;
  localparam int CoordW = 32;
  localparam int StepW  = 31;
  localparam int IterW  = 16;
  localparam int PerW   = 10;
  localparam int ChanW  = 8;

  // z components: |xx - yy + c| stays below 2^33 with margin
  localparam int ZW    = FracBits + 6;
  localparam int MagW  = FracBits + 1;   // multiplier operand, |x| < 2
  localparam int SqW   = FracBits + 2;   // truncated square, < 4
  localparam int XyW   = FracBits + 3;   // truncated cross term, < 8
  localparam int CSumW = StepW + ColW + 2;

  // shared divider
  localparam int DivW     = 18;
  localparam int DivStepW = $clog2(DivW + 1);

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgRealOrigin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImagOrigin = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRealStep   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgImagStep   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMaxIter    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPeriod     = 3'd5;

  localparam logic [CoordW-1:0] RealOriginRst = 32'hE000_0000;
  localparam logic [CoordW-1:0] ImagOriginRst = 32'hEE00_0000;
  localparam logic [StepW-1:0]  RealStepRst   = 31'd671508;
  localparam logic [StepW-1:0]  ImagStepRst   = 31'd671835;
  localparam logic [IterW-1:0]  MaxIterRst    = 16'd1000;
  localparam logic [PerW-1:0]   PeriodRst     = 10'd50;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  typedef enum logic [1:0] {
    DIV_MOD,
    DIV_SECT,
    DIV_RAMP
  } div_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C_MUL,
    ST_C_ADD,
    ST_IT_CHECK,
    ST_IT_UPDATE,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_SECT_GO,
    ST_SECT_WAIT,
    ST_RAMP_GO,
    ST_RAMP_WAIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ColW-1:0] column;
    logic [RowW-1:0] row;
  } pixel_in_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [IterW-1:0] iteration_count;
    logic             inside_res;
  } pixel_out_t;

  typedef struct packed {
    logic    load_pix;
    logic    mul_c;
    logic    set_c;
    logic    mul_z;
    logic    step_z;
    logic    div_start;
    div_op_e div_op;
    logic    cap_mod;
    logic    cap_sect;
    logic    load_colour;
    logic    load_inside;
  } cmd_t;

  typedef struct packed {
    logic lim_hit;
    logic big;
    logic sq_esc;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

@@ src/escape_time_fractal_pixel_top.sv @@
// Top level of the escape-time fractal pixel block: controller plus datapath.
// Depends on etfp_pkg, etfp_ctrl, etfp_dp (and etfp_div below it).
//
// Use:
//  - A pixel beat (column, row) is taken at a rising edge with start high and
//    busy low. busy stays high until the result has been shown.
//  - The result beat (colour, iteration count, inside flag) is valid on res_o
//    when done_o pulses high for exactly one cycle. The receiver cannot stall it;
//    it must take the beat in that cycle.
//  - Each iteration passes through a check state and an update state, with the
//    three registered multipliers between them; for an escaping pixel the colour
//    map then runs three divides in turn on one shared bit-serial divider.
//  - One pixel is worked on at a time; the next start is taken the cycle after
//    done_o.
//  - Configuration beats (cfg_valid_i, cfg_index_i, cfg_data_i) are always
//    accepted; they are meant to be written only while busy is low.
//  - Reset (rst_ni low, asynchronous) returns the controller to idle and loads
//    the default view window, a limit of 1000 and a hue period of 50.
`default_nettype none

module escape_time_fractal_pixel_top
  import etfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire pixel_in_t           pixel_i,
  output logic                     busy,
  output logic                     done_o,
  output pixel_out_t               res_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // config registers never stall a write
  assign cfg_ready_o = 1'b1;

  etfp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .busy     (busy),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  etfp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_i     (pixel_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

@@ src/etfp_div.sv @@
// Restoring divider, one quotient bit per cycle, for the colour map.
// Depends on etfp_pkg.
`default_nettype none

module etfp_div
  import etfp_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DivW-1:0] dividend_i,
  input  wire logic [PerW-1:0] divisor_i,
  output logic                 done_o,
  output logic [DivW-1:0]      quot_o,
  output logic [PerW-1:0]      rem_o
);

  logic [DivW-1:0]     dvd_q, dvd_d;
  logic [PerW-1:0]     dsr_q;
  logic [PerW-1:0]     rem_q, rem_d;
  logic [DivStepW-1:0] cnt_q;
  logic                run_q;
  logic                done_q;
  logic [PerW:0]       trial;
  logic [PerW:0]       diff;
  logic                fits;

  always_comb begin
    trial = {rem_q, dvd_q[DivW-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = (trial >= {1'b0, dsr_q});
    rem_d = fits ? diff[PerW-1:0] : trial[PerW-1:0];
    dvd_d = {dvd_q[DivW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == DivStepW'(1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DivStepW'(DivW);
      end else if (run_q) begin
        cnt_q <= cnt_q - DivStepW'(1);
        run_q <= (cnt_q != DivStepW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

@@ src/etfp_ctrl.sv @@
// Controller state machine: sequences c set-up, the z iteration loop and the
// three divides of the colour map. Depends on etfp_pkg.
`default_nettype none

module etfp_ctrl
  import etfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start,
  input  wire status_t status_i,
  output logic         busy,
  output logic         done_o,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_C_MUL;
      end
      ST_C_MUL:  state_d = ST_C_ADD;
      ST_C_ADD:  state_d = ST_IT_CHECK;
      ST_IT_CHECK: begin
        if (status_i.lim_hit)  state_d = ST_DONE;
        else if (status_i.big) state_d = ST_MOD_GO;
        else                   state_d = ST_IT_UPDATE;
      end
      ST_IT_UPDATE: begin
        state_d = status_i.sq_esc ? ST_MOD_GO : ST_IT_CHECK;
      end
      ST_MOD_GO:  state_d = ST_MOD_WAIT;
      ST_MOD_WAIT: begin
        if (status_i.div_done) state_d = ST_SECT_GO;
      end
      ST_SECT_GO: state_d = ST_SECT_WAIT;
      ST_SECT_WAIT: begin
        if (status_i.div_done) state_d = ST_RAMP_GO;
      end
      ST_RAMP_GO: state_d = ST_RAMP_WAIT;
      ST_RAMP_WAIT: begin
        if (status_i.div_done) state_d = ST_DONE;
      end
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.div_op = DIV_MOD;
    busy         = 1'b1;
    done_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy           = 1'b0;
        cmd_o.load_pix = start;
      end
      ST_C_MUL: cmd_o.mul_c = 1'b1;
      ST_C_ADD: cmd_o.set_c = 1'b1;
      ST_IT_CHECK: begin
        cmd_o.load_inside = status_i.lim_hit;
        cmd_o.mul_z       = !status_i.lim_hit && !status_i.big;
      end
      ST_IT_UPDATE: cmd_o.step_z = !status_i.sq_esc;
      ST_MOD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_MOD;
      end
      ST_MOD_WAIT: cmd_o.cap_mod = status_i.div_done;
      ST_SECT_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_SECT;
      end
      ST_SECT_WAIT: cmd_o.cap_sect = status_i.div_done;
      ST_RAMP_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_RAMP;
      end
      ST_RAMP_WAIT: cmd_o.load_colour = status_i.div_done;
      ST_DONE:      done_o = 1'b1;
      default:      busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ src/etfp_dp.sv @@
// Datapath: configuration registers, c set-up, the z*z + c iteration with its
// three multipliers, and the hue ramp built on the shared divider.
// Depends on etfp_pkg and etfp_div.
`default_nettype none

module etfp_dp
  import etfp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_wr_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire pixel_in_t           pixel_i,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  output pixel_out_t               res_o
);

  localparam logic [ZW-1:0]  TwoFx  = ZW'(64'd1 << (FracBits + 1));
  localparam logic [XyW-1:0] FourFx = XyW'(64'd1 << (FracBits + 2));

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [CSumW-1:0] v);
    logic signed [CSumW-1:0] hi;
    logic signed [CSumW-1:0] lo;
    hi = {{(CSumW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
    lo = {{(CSumW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};
    if (v > hi)      sat_coord = hi[CoordW-1:0];
    else if (v < lo) sat_coord = lo[CoordW-1:0];
    else             sat_coord = v[CoordW-1:0];
  endfunction

  // configuration
  logic [CoordW-1:0] real_origin_q, imag_origin_q;
  logic [StepW-1:0]  real_step_q, imag_step_q;
  logic [IterW-1:0]  max_iter_q;
  logic [PerW-1:0]   period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_origin_q <= RealOriginRst;
      imag_origin_q <= ImagOriginRst;
      real_step_q   <= RealStepRst;
      imag_step_q   <= ImagStepRst;
      max_iter_q    <= MaxIterRst;
      period_q      <= PeriodRst;
    end else if (cfg_wr_i) begin
      case (cfg_index_i)
        CfgRealOrigin: real_origin_q <= cfg_data_i[CoordW-1:0];
        CfgImagOrigin: imag_origin_q <= cfg_data_i[CoordW-1:0];
        CfgRealStep:   real_step_q   <= cfg_data_i[StepW-1:0];
        CfgImagStep:   imag_step_q   <= cfg_data_i[StepW-1:0];
        CfgMaxIter:    max_iter_q    <= cfg_data_i[IterW-1:0];
        CfgPeriod:     period_q      <= cfg_data_i[PerW-1:0];
        default: ;
      endcase
    end
  end

  // pixel indices, clamped to the window
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;

  always_comb begin
    col_d = ({6'b0, pixel_i.column} > 17'(MaxColumns - 1)) ? ColW'(MaxColumns - 1)
                                                           : pixel_i.column;
    row_d = ({7'b0, pixel_i.row} > 17'(MaxRows - 1)) ? RowW'(MaxRows - 1) : pixel_i.row;
  end

  // c = origin + index * step
  logic [ColW+StepW-1:0]    prod_re_q;
  logic [RowW+StepW-1:0]    prod_im_q;
  logic signed [CSumW-1:0]  csum_re, csum_im;
  logic signed [CoordW-1:0] cr_q, ci_q;

  always_comb begin
    csum_re = $signed({{(CSumW-CoordW){real_origin_q[CoordW-1]}}, real_origin_q})
            + $signed({{(CSumW-ColW-StepW){1'b0}}, prod_re_q});
    csum_im = $signed({{(CSumW-CoordW){imag_origin_q[CoordW-1]}}, imag_origin_q})
            + $signed({{(CSumW-RowW-StepW){1'b0}}, prod_im_q});
  end

  // z iteration
  logic signed [ZW-1:0] x_q, y_q, x_d, y_d;
  logic [ZW-1:0]        ax, ay;
  logic [MagW-1:0]      mx, my;
  logic [2*MagW-1:0]    xx_full, yy_full;
  logic [2*MagW:0]      xy_full;
  logic [SqW-1:0]       xx_q, yy_q;
  logic [XyW-1:0]       xy_q;
  logic                 xy_neg_q;
  logic [XyW-1:0]       sq_sum;
  logic signed [ZW-1:0] xy_s;
  logic [IterW-1:0]     n_q;

  always_comb begin
    ax      = x_q[ZW-1] ? ZW'(-x_q) : ZW'(x_q);
    ay      = y_q[ZW-1] ? ZW'(-y_q) : ZW'(y_q);
    mx      = ax[MagW-1:0];
    my      = ay[MagW-1:0];
    xx_full = {{MagW{1'b0}}, mx} * {{MagW{1'b0}}, mx};
    yy_full = {{MagW{1'b0}}, my} * {{MagW{1'b0}}, my};
    xy_full = {{(MagW+1){1'b0}}, mx} * {{MagW{1'b0}}, my, 1'b0};
    sq_sum  = {1'b0, xx_q} + {1'b0, yy_q};
    xy_s    = xy_neg_q ? -$signed({{(ZW-XyW){1'b0}}, xy_q})
                       :  $signed({{(ZW-XyW){1'b0}}, xy_q});
    x_d     = $signed({{(ZW-SqW){1'b0}}, xx_q}) - $signed({{(ZW-SqW){1'b0}}, yy_q})
            + $signed({{(ZW-CoordW){cr_q[CoordW-1]}}, cr_q});
    y_d     = xy_s + $signed({{(ZW-CoordW){ci_q[CoordW-1]}}, ci_q});
  end

  assign status_o.lim_hit = (n_q >= max_iter_q);
  assign status_o.big     = (ax >= TwoFx) || (ay >= TwoFx);
  assign status_o.sq_esc  = (sq_sum >= FourFx);

  // colour map
  logic [PerW-1:0]  p_eff;
  logic [DivW-1:0]  dividend;
  logic             div_done;
  logic [DivW-1:0]  quot;
  logic [PerW-1:0]  rem;
  logic [PerW-1:0]  m_q, rise_q;
  logic [2:0]       sector_q;
  logic [ChanW-1:0] rc, fc;
  pixel_out_t       res_q;

  always_comb begin
    p_eff = (period_q == '0) ? PerW'(1) : period_q;
    case (cmd_i.div_op)
      DIV_MOD:  dividend = DivW'(n_q);
      DIV_SECT: dividend = DivW'({m_q, 2'b00}) + DivW'({m_q, 1'b0});
      DIV_RAMP: dividend = DivW'({rise_q, 8'b0}) - DivW'(rise_q);
      default:  dividend = DivW'(n_q);
    endcase
    rc = quot[ChanW-1:0];
    fc = ChanMax - rc - ChanW'(rem != '0);
  end

  etfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (p_eff),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign status_o.div_done = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pix) begin
      col_q <= col_d;
      row_q <= row_d;
    end
    if (cmd_i.mul_c) begin
      prod_re_q <= {{StepW{1'b0}}, col_q} * {{ColW{1'b0}}, real_step_q};
      prod_im_q <= {{StepW{1'b0}}, row_q} * {{RowW{1'b0}}, imag_step_q};
    end
    if (cmd_i.set_c) begin
      cr_q <= sat_coord(csum_re);
      ci_q <= sat_coord(csum_im);
      x_q  <= '0;
      y_q  <= '0;
      n_q  <= IterW'(1);
    end else if (cmd_i.step_z) begin
      x_q <= x_d;
      y_q <= y_d;
      n_q <= n_q + IterW'(1);
    end
    if (cmd_i.mul_z) begin
      xx_q     <= xx_full[2*FracBits+1:FracBits];
      yy_q     <= yy_full[2*FracBits+1:FracBits];
      xy_q     <= xy_full[2*FracBits+2:FracBits];
      xy_neg_q <= x_q[ZW-1] ^ y_q[ZW-1];
    end
    if (cmd_i.cap_mod) m_q <= rem;
    if (cmd_i.cap_sect) begin
      sector_q <= quot[2:0];
      rise_q   <= rem;
    end
    if (cmd_i.load_inside) begin
      res_q.red             <= '0;
      res_q.green           <= '0;
      res_q.blue            <= '0;
      res_q.iteration_count <= n_q;
      res_q.inside_res      <= 1'b1;
    end else if (cmd_i.load_colour) begin
      res_q.iteration_count <= n_q;
      res_q.inside_res      <= 1'b0;
      case (sector_q)
        3'd0: begin
          res_q.red <= ChanMax; res_q.green <= rc;      res_q.blue <= '0;
        end
        3'd1: begin
          res_q.red <= fc;      res_q.green <= ChanMax; res_q.blue <= '0;
        end
        3'd2: begin
          res_q.red <= '0;      res_q.green <= ChanMax; res_q.blue <= rc;
        end
        3'd3: begin
          res_q.red <= '0;      res_q.green <= fc;      res_q.blue <= ChanMax;
        end
        3'd4: begin
          res_q.red <= rc;      res_q.green <= '0;      res_q.blue <= ChanMax;
        end
        default: begin
          res_q.red <= ChanMax; res_q.green <= '0;      res_q.blue <= fc;
        end
      endcase
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire
